// File: design/holonomic_goal_velocity_controller_defines.svh
// assertion macros for the goal velocity controller
`ifndef HOLONOMIC_GOAL_VELOCITY_CONTROLLER_DEFINES_SVH
`define HOLONOMIC_GOAL_VELOCITY_CONTROLLER_DEFINES_SVH
// implication checked on every clock edge out of reset
`define HGVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HGVC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: design/hgvc_pkg.sv
// ----------------------------------------------------------------------------
// hgvc_pkg
// constants, atan table and field types of the goal velocity controller
// ----------------------------------------------------------------------------
package hgvc_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TBL_LEN = 24;
  localparam int ZW = 34;
  localparam int XW = 40;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30 = 40'sd652032874;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic [31:0] FAR_SQ = 32'd37748736;
  localparam logic [31:0] NEAR_SQ = 32'd670761;
  localparam logic [31:0] CLOSE_SQ = 32'd42025;
  localparam logic [15:0] BIG_ANG = 16'd4096;
  localparam logic [15:0] SMALL_ANG = 16'd41;
  localparam logic [15:0] ONE_RAD = 16'd8192;
  localparam logic [14:0] LIN_RST = 15'd2048;
  localparam logic [14:0] ANG_RST = 15'd2458;
  localparam logic [7:0] HOLD_RST = 8'd10;

  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0: v = 34'sd843314857;
      5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043837;
      5'd3: v = 34'sd133525159;
      5'd4: v = 34'sd67021687;
      5'd5: v = 34'sd33543516;
      5'd6: v = 34'sd16775851;
      5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194283;
      5'd9: v = 34'sd2097149;
      default: v = (i < 5'd24) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic last_point;
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
    logic position_reached;
    logic goal_done;
  } out_item_t;

  // cordic control: vectoring or rotation
  typedef struct packed {
    logic start;
    logic vect;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [ZW-1:0] z0;
  } cordic_cmd_t;
endpackage

// File: design/hgvc_if.sv
// ----------------------------------------------------------------------------
// hgvc_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface hgvc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/holonomic_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// holonomic_goal_velocity_controller
// goal point to holonomic velocity command, with settling counters
// ----------------------------------------------------------------------------
// in: goal_x, goal_y (Q4.12), last_point, restart over a valid/ready channel.
// out: vel_x, vel_y, turn_rate, position_reached, goal_done, one result per
// transfer, or none when the goal is already done at the start of the tick.
// apb-style cfg port: linear_limit at 0, angular_limit at 4, hold_count at 8.
// one item at a time: two shift-add squares for the distance,
// CORDIC_STEPS vectoring steps for the bearing, CORDIC_STEPS rotation steps
// for sin/cos, then two serial products (near goal) or one product and a
// restoring divide by pi (far goal), on one shared cordic unit and one
// serial multiplier.
// the result sits in an output register; the next item is accepted while it
// waits and its last stage holds until the register is free, so a stalled
// receiver stalls the input side with nothing lost.
// reset clears counters, flag and the registers to their reset values.
// ----------------------------------------------------------------------------
`include "holonomic_goal_velocity_controller_defines.svh"
module holonomic_goal_velocity_controller import hgvc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hgvc_if.sink   in_ch,
  hgvc_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_VEC = 4'd2, S_ROT0 = 4'd3,
    S_ROT = 4'd4, S_MUL0 = 4'd5, S_MULX = 4'd6, S_MULY = 4'd7, S_FIN = 4'd8,
    S_OUT = 4'd9, S_VEC0 = 4'd10;

  logic [14:0] lin_r, ang_r;
  logic [7:0] hold_r;
  logic [7:0] ph_r, hh_r;
  logic rf_r;
  logic [3:0] st_r;
  in_item_t it_r;
  logic [31:0] d2_r;
  logic signed [15:0] a_r;
  logic signed [XW-1:0] c_r, s_r;
  logic signed [XW+15:0] px_r;
  logic fold_r;
  out_item_t o_r;
  logic out_v_r;

  cordic_cmd_t ccmd;
  logic cbusy;
  logic signed [XW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic mstart, mbusy;
  logic signed [XW-1:0] ma;
  logic [15:0] mb;
  logic signed [XW+15:0] mp;

  hgvc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .cmd(ccmd), .busy(cbusy), .x_out(cx), .y_out(cy), .z_out(cz));
  hgvc_serial_mul u_mul (
    .clk, .rst_n, .start(mstart), .a(ma), .b(mb), .busy(mbusy), .p(mp));

  // cfg port
  logic wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    case (cfg_paddr[3:2])
      2'd0: cfg_prdata = {17'd0, lin_r};
      2'd1: cfg_prdata = {17'd0, ang_r};
      2'd2: cfg_prdata = {24'd0, hold_r};
      default: cfg_prdata = '0;
    endcase
  end

  logic far, near, close;
  logic signed [15:0] absa;
  logic [7:0] ph0, hh0;
  logic done0;
  assign far = d2_r >= FAR_SQ;
  assign near = d2_r < NEAR_SQ;
  assign close = d2_r < CLOSE_SQ;
  assign absa = a_r[15] ? -a_r : a_r;
  assign ph0 = in_ch.data.restart ? 8'd0 : ph_r;
  assign hh0 = in_ch.data.restart ? 8'd0 : hh_r;
  assign done0 = (ph0 == hold_r) && (hh0 == hold_r);

  // bearing rounding, Q4.30 to Q3.13
  logic signed [ZW-1:0] zr;
  logic signed [16:0] zq;
  assign zr = (cz + 34'sd65536) >>> 17;
  assign zq = zr[16:0];

  // rotation angle
  logic signed [ZW-1:0] th, thf;
  logic thfold;
  always_comb begin
    th = far ? (ZW'(a_r) <<< 16) : (ZW'(a_r) <<< 17);
    thfold = 1'b0; thf = th;
    if (th > HALF_PI_Q30) begin thf = th - PI_Q30; thfold = 1'b1; end
    else if (th < -HALF_PI_Q30) begin thf = th + PI_Q30; thfold = 1'b1; end
  end

  function automatic logic signed [15:0] sat(input logic signed [XW+15:0] v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // magnitudes for the distance square
  logic [15:0] ax, ay;
  assign ax = it_r.goal_x[15] ? 16'(-it_r.goal_x) : 16'(it_r.goal_x);
  assign ay = it_r.goal_y[15] ? 16'(-it_r.goal_y) : 16'(it_r.goal_y);

  // divider quotient and numerator bit stream
  logic [15:0] px_r_div;
  logic [30:0] dv_num_r;
  logic dvn_bit;

  logic [3:0] st_nxt;
  logic [7:0] ph_nxt, hh_nxt;
  logic rf_nxt;
  out_item_t o_nxt;
  logic out_v_nxt;
  logic signed [XW+15:0] rnd;
  logic signed [15:0] w;
  logic [1:0] sq_r, sq_nxt;
  logic signed [XW-1:0] cxf, cyf;

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; hh_nxt = hh_r; rf_nxt = rf_r;
    o_nxt = o_r; out_v_nxt = out_v_r; sq_nxt = sq_r;
    ccmd = '0; mstart = 1'b0; ma = c_r; mb = {1'b0, lin_r};
    rnd = '0; w = '0;
    cxf = fold_r ? -cx : cx;
    cyf = fold_r ? -cy : cy;
    if (out_v_r && out_ch.ready) out_v_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          ph_nxt = ph0; hh_nxt = hh0;
          if (in_ch.data.restart) rf_nxt = 1'b0;
          if (!done0) st_nxt = S_SQ;
          sq_nxt = 2'd0;
        end
      end
      S_SQ: begin
        // x*x then y*y through the serial multiplier
        ma = (sq_r[0]) ? XW'(ay) : XW'(ax);
        mb = (sq_r[0]) ? ay : ax;
        if (!mbusy) begin
          if (sq_r == 2'd0) begin mstart = 1'b1; sq_nxt = 2'd1; end
          else begin
            if (sq_r == 2'd1) begin
              mstart = 1'b1; sq_nxt = 2'd3;
            end else st_nxt = S_VEC0;
          end
        end
      end
      S_VEC0: begin
        ccmd.start = 1'b1; ccmd.vect = 1'b1;
        ccmd.x0 = XW'(it_r.goal_x) <<< 14; ccmd.y0 = XW'(it_r.goal_y) <<< 14;
        ccmd.z0 = '0;
        if (it_r.goal_x[15]) begin
          if (!it_r.goal_y[15]) begin
            ccmd.x0 = XW'(it_r.goal_y) <<< 14; ccmd.y0 = -(XW'(it_r.goal_x) <<< 14);
            ccmd.z0 = HALF_PI_Q30;
          end else begin
            ccmd.x0 = -(XW'(it_r.goal_y) <<< 14); ccmd.y0 = XW'(it_r.goal_x) <<< 14;
            ccmd.z0 = -HALF_PI_Q30;
          end
        end
        st_nxt = S_VEC;
      end
      S_VEC: if (!cbusy) st_nxt = S_ROT0;
      S_ROT0: begin
        ccmd.start = 1'b1; ccmd.vect = 1'b0;
        ccmd.x0 = GAIN_Q30; ccmd.y0 = '0; ccmd.z0 = thf;
        st_nxt = S_ROT;
      end
      S_ROT: if (!cbusy) st_nxt = S_MUL0;
      S_MUL0: begin
        if (far) begin
          // vel_x = lin - round(lin*|a|/pi) via reciprocal-free serial product
          ma = XW'(absa); mstart = 1'b1; st_nxt = S_MULX;
        end else begin
          ma = cxf; mstart = 1'b1; st_nxt = S_MULX;
        end
      end
      S_MULX: begin
        if (!mbusy) begin
          ma = s_r; mstart = !far; st_nxt = far ? S_FIN : S_MULY;
        end
      end
      S_MULY: if (!mbusy) st_nxt = S_FIN;
      S_FIN: begin
        // wait here while the previous result still sits in the output register
        if (!out_v_r) begin
          o_nxt = '0;
          if (far) begin
            rnd = (XW+16)'((s_r + 40'sd131072) >>> 18);
            w = sat(rnd);
            if (w > $signed({1'b0, ang_r})) w = $signed({1'b0, ang_r});
            if (w < -$signed({1'b0, ang_r})) w = -$signed({1'b0, ang_r});
            o_nxt.turn_rate = w;
            if (absa < $signed(ONE_RAD))
              o_nxt.vel_x = $signed({1'b0, lin_r}) - 16'(px_r_div);
          end else begin
            if (near) begin
              if (it_r.last_point) begin
                if (ph_r < hold_r) begin
                  o_nxt.vel_x = sat((px_r + (56'sd1 <<< 31)) >>> 32);
                  o_nxt.vel_y = sat((mp + (56'sd1 <<< 31)) >>> 32);
                end
                if (close) begin
                  if (ph_r != 8'd255) ph_nxt = ph_r + 8'd1;
                  if (((ph_r != 8'd255) ? ph_r + 8'd1 : ph_r) == hold_r) rf_nxt = 1'b1;
                end else ph_nxt = '0;
              end
            end else begin
              o_nxt.vel_x = sat((px_r + (56'sd1 <<< 29)) >>> 30);
              o_nxt.vel_y = sat((mp + (56'sd1 <<< 29)) >>> 30);
            end
            if (hh_r < hold_r) begin
              if (absa > $signed(BIG_ANG)) begin
                o_nxt.turn_rate = a_r[15] ? -$signed({1'b0, ang_r}) : $signed({1'b0, ang_r});
              end else if (absa > $signed(SMALL_ANG)) begin
                o_nxt.turn_rate = (a_r + 16'sd1) >>> 1;
                hh_nxt = '0;
              end else if (it_r.last_point) begin
                if (hh_r != 8'd255) hh_nxt = hh_r + 8'd1;
              end
            end
          end
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        o_nxt.position_reached = rf_r;
        o_nxt.goal_done = (ph_r == hold_r) && (hh_r == hold_r);
        out_v_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // lin*|a| rounded and divided by pi: restoring divider, one quotient bit a cycle
  logic [30:0] dv_rem_r, dv_rem_nxt;
  logic [15:0] dv_q_r, dv_q_nxt;
  logic [4:0] dv_n_r, dv_n_nxt;
  logic [31:0] dv_t;
  always_comb begin
    dv_rem_nxt = dv_rem_r; dv_q_nxt = dv_q_r; dv_n_nxt = dv_n_r;
    dv_t = '0;
    if (st_r == S_MULX && far && !mbusy) begin
      dv_rem_nxt = '0;
      dv_q_nxt = '0;
      dv_n_nxt = 5'd31;
    end else if (dv_n_r != 5'd0) begin
      dv_t = {dv_rem_r, dvn_bit};
      if (dv_t >= 32'(PI_Q13)) begin
        dv_rem_nxt = 31'(dv_t - 32'(PI_Q13)); dv_q_nxt = {dv_q_r[14:0], 1'b1};
      end else begin
        dv_rem_nxt = dv_t[30:0]; dv_q_nxt = {dv_q_r[14:0], 1'b0};
      end
      dv_n_nxt = dv_n_r - 5'd1;
    end
  end
  assign dvn_bit = dv_num_r[30];
  assign px_r_div = dv_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r <= LIN_RST; ang_r <= ANG_RST; hold_r <= HOLD_RST;
      ph_r <= '0; hh_r <= '0; rf_r <= 1'b0;
      st_r <= S_IDLE; out_v_r <= 1'b0; sq_r <= '0; dv_n_r <= '0;
    end else begin
      if (wr) begin
        case (cfg_paddr[3:2])
          2'd0: lin_r <= cfg_pwdata[14:0];
          2'd1: ang_r <= cfg_pwdata[14:0];
          2'd2: hold_r <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      ph_r <= ph_nxt; hh_r <= hh_nxt; rf_r <= rf_nxt;
      out_v_r <= out_v_nxt; sq_r <= sq_nxt; dv_n_r <= dv_n_nxt;
      // the divider runs while in S_FIN; hold S_FIN until it finishes
      if (st_r == S_FIN && far && dv_n_nxt != 5'd0) st_r <= S_FIN;
      else if (st_r == S_FIN && far && dv_n_r != 5'd0) st_r <= S_FIN;
      else st_r <= st_nxt;
    end
    dv_rem_r <= dv_rem_nxt; dv_q_r <= dv_q_nxt;
    if (st_r == S_MULX && far && !mbusy) dv_num_r <= 31'(mp) + 31'(PI_Q13 >>> 1);
    else if (dv_n_r != 5'd0) dv_num_r <= {dv_num_r[29:0], 1'b0};
    if (st_r == S_IDLE && in_ch.valid) it_r <= in_ch.data;
    if (st_r == S_SQ && !mbusy && sq_r == 2'd1) d2_r <= 32'(mp);
    if (st_r == S_SQ && !mbusy && sq_r == 2'd3) d2_r <= d2_r + 32'(mp);
    if (st_r == S_VEC && !cbusy) begin
      if (it_r.goal_x == 16'sd0 && it_r.goal_y == 16'sd0) a_r <= '0;
      else if (zq > 17'sd25736) a_r <= PI_Q13;
      else if (zq < -17'sd25736) a_r <= -PI_Q13;
      else a_r <= zq[15:0];
    end
    if (st_r == S_ROT0) fold_r <= thfold;
    if (st_r == S_ROT && !cbusy) begin c_r <= cxf; s_r <= cyf; end
    if (st_r == S_MULX && !mbusy) px_r <= mp;
    if (st_r == S_FIN && !out_v_r && !(far && dv_n_r != 5'd0)) o_r <= o_nxt;
    else if (st_r == S_OUT) o_r <= o_nxt;
  end

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data = o_r;

  `HGVC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, !in_ch.ready,
    "input accepted while busy")
  `HGVC_ASSERT_NXT(a_out_hold, clk, rst_n, out_v_r && !out_ch.ready, out_v_r,
    "result dropped while stalled")
  `HGVC_ASSERT_NXT(a_out_from_fin, clk, rst_n, st_r == S_OUT, out_v_r,
    "finished item not presented")
endmodule

// File: design/hgvc_cordic.sv
// ----------------------------------------------------------------------------
// hgvc_cordic
// shared cordic unit, one micro-rotation per cycle, vectoring or rotation
// ----------------------------------------------------------------------------
module hgvc_cordic import hgvc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cordic_cmd_t cmd,
  output logic busy,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);
  localparam int N = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic busy_r, busy_nxt, vect_r, vect_nxt, dir;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; vect_nxt = vect_r;
    dir = vect_r ? (y_r > 0) : (z_r >= 0);
    if (cmd.start) begin
      x_nxt = cmd.x0; y_nxt = cmd.y0; z_nxt = cmd.z0;
      i_nxt = '0; busy_nxt = 1'b1; vect_nxt = cmd.vect;
    end else if (busy_r) begin
      if (vect_r) begin
        x_nxt = dir ? x_r + (y_r >>> i_r) : x_r - (y_r >>> i_r);
        y_nxt = dir ? y_r - (x_r >>> i_r) : y_r + (x_r >>> i_r);
        z_nxt = dir ? z_r + atan_at(i_r) : z_r - atan_at(i_r);
      end else begin
        x_nxt = dir ? x_r - (y_r >>> i_r) : x_r + (y_r >>> i_r);
        y_nxt = dir ? y_r + (x_r >>> i_r) : y_r - (x_r >>> i_r);
        z_nxt = dir ? z_r - atan_at(i_r) : z_r + atan_at(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(N - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= '0;
      vect_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      i_r <= i_nxt;
      vect_r <= vect_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end

  assign busy = busy_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule

// File: design/hgvc_serial_mul.sv
// ----------------------------------------------------------------------------
// hgvc_serial_mul
// shift-add multiplier, one bit of the unsigned multiplier per cycle
// ----------------------------------------------------------------------------
module hgvc_serial_mul import hgvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [XW-1:0] a,
  input  logic [15:0] b,
  output logic busy,
  output logic signed [XW+15:0] p
);
  logic signed [XW+15:0] acc_r, acc_nxt, m_r, m_nxt;
  logic [15:0] b_r, b_nxt;
  logic [4:0] n_r, n_nxt;

  always_comb begin
    acc_nxt = acc_r; m_nxt = m_r; b_nxt = b_r; n_nxt = n_r;
    if (start) begin
      acc_nxt = '0; m_nxt = (XW+16)'(a); b_nxt = b; n_nxt = 5'd16;
    end else if (n_r != 5'd0) begin
      if (b_r[0]) acc_nxt = acc_r + m_r;
      m_nxt = m_r <<< 1;
      b_nxt = b_r >> 1;
      n_nxt = n_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= '0;
    else n_r <= n_nxt;
    acc_r <= acc_nxt; m_r <= m_nxt; b_r <= b_nxt;
  end

  assign busy = (n_r != 5'd0);
  assign p = acc_r;
endmodule
